/* sv/murm_pkg.sv */
// Shared constants, types and helpers for the MurmurHash64A engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package murm_pkg;

    localparam logic [63:0] MixMul    = 64'hc6a4a7935bd1e995;
    localparam int unsigned MixShift  = 47;
    localparam int unsigned TailMax   = 7;

    // Config port
    localparam int unsigned CfgAddrW  = 4;
    localparam int unsigned CfgDataW  = 64;
    localparam logic [CfgAddrW-1:0] AddrHashSeed = 4'h0;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SEED_W = 9'b000000010,
        S_BODY   = 9'b000000100,
        S_K1_W   = 9'b000001000,
        S_K2_W   = 9'b000010000,
        S_H_W    = 9'b000100000,
        S_FIN    = 9'b001000000,
        S_FIN_W  = 9'b010000000,
        S_EMIT   = 9'b100000000
    } t_state;

    // Keep the low nb bytes; counts above the tail limit keep the whole word.
    function automatic logic [63:0] byte_mask(input logic [3:0] nb);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < nb) begin
                m[8*b +: 8] = 8'hff;
            end
        end
        if (nb > 4'(TailMax)) begin
            m = '1;
        end
        return m;
    endfunction

    function automatic logic [63:0] xor_shift(input logic [63:0] v);
        return v ^ (v >> MixShift);
    endfunction

endpackage

`default_nettype wire

/* sv/murm_in_if.sv */
// Input channel: message words with byte count and framing flags.
// No dependencies.
`default_nettype none

interface murm_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        first_word;
    logic        last_word;
    logic [30:0] message_length;

    modport source (output valid, data_word, valid_bytes, first_word, last_word,
                    message_length, input ready);
    modport sink   (input valid, data_word, valid_bytes, first_word, last_word,
                    message_length, output ready);
endinterface

`default_nettype wire

/* sv/murm_out_if.sv */
// Output channel: finalized 64-bit hash.
// No dependencies.
`default_nettype none

interface murm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

`default_nettype wire

/* sv/murm_mul64.sv */
// Shared 64x64 (low half) multiplier by the mix constant, built from one
// 32x32 multiplier used in turn for the low product and the two cross terms. Depends on murm_pkg.
`default_nettype none

module murm_mul64 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    output logic      [63:0] o_prod,
    output logic             o_done
);
    import murm_pkg::*;

    localparam logic [1:0] StepLo    = 2'd0;
    localparam logic [1:0] StepHiA   = 2'd1;
    localparam logic [1:0] StepHiM   = 2'd2;

    logic [63:0] r_a;
    logic [63:0] r_acc;
    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_done;

    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;

    // lo*lo, then the two cross terms into the upper half
    assign mul_x = (r_step == StepHiA) ? r_a[63:32] : r_a[31:0];
    assign mul_y = (r_step == StepHiM) ? MixMul[63:32] : MixMul[31:0];
    assign mul_p = 64'(mul_x) * 64'(mul_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= StepLo;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= StepLo;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == StepHiM) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
        end else if (r_busy) begin
            if (r_step == StepLo) begin
                r_acc <= mul_p;
            end else begin
                r_acc <= r_acc + {mul_p[31:0], 32'd0};
            end
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

`default_nettype wire

/* sv/murm_cfg.sv */
// APB-style register port holding the 64-bit hash seed.
// Depends on murm_pkg.
`default_nettype none

module murm_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [murm_pkg::CfgAddrW-1:0] paddr,
    input  wire logic [murm_pkg::CfgDataW-1:0] pwdata,
    output logic      [murm_pkg::CfgDataW-1:0] prdata,
    output logic                               pready,
    output logic      [63:0]                   o_seed
);
    import murm_pkg::*;

    logic [63:0] r_seed;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (psel && penable && pwrite && (paddr == AddrHashSeed)) begin
            r_seed <= pwdata;
        end
    end

    assign prdata = (paddr == AddrHashSeed) ? r_seed : '0;
    assign o_seed = r_seed;

endmodule

`default_nettype wire

/* sv/murmur64a_hash_engine.sv */
// channel   dir   handshake      word
// i_in      in    valid/ready    data_word, valid_bytes, first/last, length
// o_out     out   valid/ready    hash_value
// cfg       in    APB, pready=1  hash_seed at byte address 0
//
// One word at a time, each 64-bit multiply run on the shared 32x32 multiplier.
// A full word takes three multiplies, a tail one and an empty word none; a first
// word adds one (seed), a last word one more (finalize) and the output load.
// Synchronous active-low reset clears the running hash and the sequencer.
// A result waits in the output register; a following last word stalls only
// if that register is still full when its own hash is ready.
// Depends on murm_pkg, murm_in_if, murm_out_if, murm_mul64, murm_cfg.
`default_nettype none

module murmur64a_hash_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    murm_in_if.sink                            i_in,
    murm_out_if.source                         o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [murm_pkg::CfgAddrW-1:0] paddr,
    input  wire logic [murm_pkg::CfgDataW-1:0] pwdata,
    output logic      [murm_pkg::CfgDataW-1:0] prdata,
    output logic                               pready
);
    import murm_pkg::*;

    t_state      r_state, n_state;
    logic [63:0] r_h, n_h;
    logic [63:0] r_word, n_word;
    logic        r_full, n_full;
    logic        r_empty, n_empty;
    logic        r_last, n_last;
    logic [63:0] r_hash, n_hash;
    logic        r_ov, n_ov;

    logic        mul_go;
    logic [63:0] mul_a;
    logic [63:0] mul_p;
    logic        mul_done;
    logic [63:0] seed;
    logic        in_acc;

    murm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_seed  (seed)
    );

    murm_mul64 u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_go),
        .i_a     (mul_a),
        .o_prod  (mul_p),
        .o_done  (mul_done)
    );

    assign i_in.ready      = (r_state == S_IDLE);
    assign in_acc          = i_in.valid && i_in.ready;
    assign o_out.valid     = r_ov;
    assign o_out.hash_value = r_hash;

    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_word  = r_word;
        n_full  = r_full;
        n_empty = r_empty;
        n_last  = r_last;
        n_hash  = r_hash;
        n_ov    = r_ov && !o_out.ready;
        mul_go  = 1'b0;
        mul_a   = r_h;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_word  = i_in.data_word & byte_mask(i_in.valid_bytes);
                    n_full  = (i_in.valid_bytes > 4'(TailMax));
                    n_empty = (i_in.valid_bytes == 4'd0);
                    n_last  = i_in.last_word;
                    if (i_in.first_word) begin
                        mul_go  = 1'b1;
                        mul_a   = {33'd0, i_in.message_length};
                        n_state = S_SEED_W;
                    end else begin
                        n_state = S_BODY;
                    end
                end
            end
            S_SEED_W: begin
                if (mul_done) begin
                    n_h     = seed ^ mul_p;
                    n_state = S_BODY;
                end
            end
            S_BODY: begin
                if (r_full) begin
                    mul_go  = 1'b1;
                    mul_a   = r_word;
                    n_state = S_K1_W;
                end else if (r_empty) begin
                    n_state = r_last ? S_FIN : S_IDLE;
                end else begin
                    // tail: xor in the masked bytes, multiply once
                    mul_go  = 1'b1;
                    mul_a   = r_h ^ r_word;
                    n_state = S_H_W;
                end
            end
            S_K1_W: begin
                if (mul_done) begin
                    mul_go  = 1'b1;
                    mul_a   = xor_shift(mul_p);
                    n_state = S_K2_W;
                end
            end
            S_K2_W: begin
                if (mul_done) begin
                    mul_go  = 1'b1;
                    mul_a   = r_h ^ mul_p;
                    n_state = S_H_W;
                end
            end
            S_H_W: begin
                if (mul_done) begin
                    n_h     = mul_p;
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                mul_go  = 1'b1;
                mul_a   = xor_shift(r_h);
                n_state = S_FIN_W;
            end
            S_FIN_W: begin
                if (mul_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // product stays in the multiplier until the next start
                if (!r_ov || o_out.ready) begin
                    n_hash  = xor_shift(mul_p);
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_h     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_h     <= n_h;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_full  <= n_full;
        r_empty <= n_empty;
        r_last  <= n_last;
        r_hash  <= n_hash;
    end

`ifndef ASSERT_OFF
    a_first_seeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.first_word |=> r_state == S_SEED_W)
        else $error("first word did not start seeding");

    a_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_SEED_W || r_state == S_K1_W
                      || r_state == S_K2_W || r_state == S_H_W
                      || r_state == S_FIN_W))
        else $error("multiplier finished outside a wait state");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_EMIT))
        else $error("result loaded outside emit");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_go |=> !mul_done ##1 !mul_done)
        else $error("multiplier done too early");
`endif

endmodule

`default_nettype wire
